// ===== rtl/srk_pkg.sv =====
// ----------------------------------------------------------------------------
// srk_pkg
// Shared types and constants for the symmetric rank-K update block.
// ----------------------------------------------------------------------------
package srk_pkg;

    localparam int CFG_AW = 4;

    localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic        ACCUM_RESET = 1'b1;
    localparam logic [3:0]  ROWS_RESET  = 4'd8;
    localparam logic [3:0]  COLS_RESET  = 4'd8;

    typedef enum logic [1:0] {
        KIND_LOAD_X = 2'd0,
        KIND_LOAD_A = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ALPHA      = 2'd0,
        REG_ACCUMULATE = 2'd1,
        REG_ROWS_USED  = 2'd2,
        REG_COLS_USED  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] alpha;
        logic        accumulate;
        logic [3:0]  rows_used;
        logic [3:0]  cols_used;
    } cfg_t;

    typedef struct packed {
        logic load_x;
        logic load_a;
        logic read_a;
        logic set_live;
        logic clr_flag;
        logic a_rd_old;
        logic mac_issue;
        logic mac_first;
        logic mac_last;
        logic sum_zero;
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic rnd;
        logic write_back;
    } cmd_t;

    typedef struct packed {
        logic sum_done;
    } status_t;

endpackage

// ===== rtl/symmetric_rank_k_update.sv =====
// ----------------------------------------------------------------------------
// symmetric_rank_k_update
// Lower-triangle A = alpha*x*x^T (or A += ...) in signed Q16.16, saturating.
// ----------------------------------------------------------------------------
// Load and read transactions are taken one per cycle while busy is low; a
// read result is registered, then shown for a single cycle, marked by
// done, and the receiver cannot stall it. An update holds busy high while it
// clears all MAX_ORDER*MAX_ORDER clip flags (one store entry a cycle), then
// walks the lower triangle: per entry it reads old A, runs the MAC over K
// columns of x (zero sum if K is 0), scales by alpha, rounds, writes back.
// The length is set by the single multiplier, which takes one x product a
// cycle, then both halves of alpha scaling, and by the one flag write port.
module symmetric_rank_k_update #(
    parameter int MAX_ORDER = 8,
    parameter int MAX_RANK  = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 kind,
    input  logic [2:0]                 row,
    input  logic [2:0]                 col,
    input  logic signed [31:0]         value,
    output logic                       done,
    output logic signed [31:0]         read_value,
    output logic                       saturated,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srk_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import srk_pkg::*;

    localparam int OW  = $clog2(MAX_ORDER);
    localparam int RW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int AAW = $clog2(MAX_ORDER * MAX_ORDER);

    cfg_t           cfg;
    cmd_t           cmd;
    status_t        status;
    logic [OW-1:0]  i_idx, j_idx;
    logic [RW-1:0]  c_idx;
    logic [AAW-1:0] clr_addr;

    srk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srk_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .MAX_RANK  (MAX_RANK)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .kind     (kind),
        .cfg      (cfg),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd),
        .i_idx    (i_idx),
        .j_idx    (j_idx),
        .c_idx    (c_idx),
        .clr_addr (clr_addr)
    );

    srk_dpath #(
        .MAX_ORDER (MAX_ORDER),
        .MAX_RANK  (MAX_RANK)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .row        (row),
        .col        (col),
        .value      (value),
        .i_idx      (i_idx),
        .j_idx      (j_idx),
        .c_idx      (c_idx),
        .clr_addr   (clr_addr),
        .done       (done),
        .read_value (read_value),
        .saturated  (saturated)
    );

endmodule

// ===== rtl/srk_cfg.sv =====
// ----------------------------------------------------------------------------
// srk_cfg
// APB-style configuration registers: alpha, accumulate, rows_used, cols_used.
// ----------------------------------------------------------------------------
module srk_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [srk_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output srk_pkg::cfg_t             cfg
);
    import srk_pkg::*;

    logic [31:0] alpha_reg;
    logic        accumulate_reg;
    logic [3:0]  rows_reg;
    logic [3:0]  cols_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= ALPHA_RESET;
            accumulate_reg <= ACCUM_RESET;
            rows_reg       <= ROWS_RESET;
            cols_reg       <= COLS_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ALPHA:      alpha_reg      <= pwdata;
                REG_ACCUMULATE: accumulate_reg <= pwdata[0];
                REG_ROWS_USED:  rows_reg       <= pwdata[3:0];
                REG_COLS_USED:  cols_reg       <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ALPHA:      prdata = alpha_reg;
            REG_ACCUMULATE: prdata = {31'd0, accumulate_reg};
            REG_ROWS_USED:  prdata = {28'd0, rows_reg};
            REG_COLS_USED:  prdata = {28'd0, cols_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.alpha      = alpha_reg;
    assign cfg.accumulate = accumulate_reg;
    assign cfg.rows_used  = rows_reg;
    assign cfg.cols_used  = cols_reg;

endmodule

// ===== rtl/srk_ctrl.sv =====
// ----------------------------------------------------------------------------
// srk_ctrl
// Controller: accepts transactions, sequences the flag clear and the walk
// over the lower triangle, and issues datapath commands.
// ----------------------------------------------------------------------------
module srk_ctrl #(
    parameter  int MAX_ORDER = 8,
    parameter  int MAX_RANK  = 8,
    localparam int OW  = $clog2(MAX_ORDER),
    localparam int RW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
    localparam int AAW = $clog2(MAX_ORDER * MAX_ORDER),
    localparam int NW  = $clog2(MAX_ORDER + 1),
    localparam int KW  = $clog2(MAX_RANK + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  srk_pkg::cfg_t     cfg,
    input  srk_pkg::status_t  status,
    output logic              busy,
    output srk_pkg::cmd_t     cmd,
    output logic [OW-1:0]     i_idx,
    output logic [OW-1:0]     j_idx,
    output logic [RW-1:0]     c_idx,
    output logic [AAW-1:0]    clr_addr
);
    import srk_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CLEAR   = 10'b00_0000_0010,
        S_ENTRY   = 10'b00_0000_0100,
        S_MAC     = 10'b00_0000_1000,
        S_DRAIN   = 10'b00_0001_0000,
        S_SCL_LO  = 10'b00_0010_0000,
        S_SCL_HI  = 10'b00_0100_0000,
        S_COMBINE = 10'b00_1000_0000,
        S_ROUND   = 10'b01_0000_0000,
        S_WRITE   = 10'b10_0000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [OW-1:0]  i_reg, i_next;
    logic [OW-1:0]  j_reg, j_next;
    logic [RW-1:0]  c_reg, c_next;
    logic [AAW-1:0] clr_reg, clr_next;
    logic [NW-1:0]  n_lim;
    logic [KW-1:0]  k_lim;
    logic           accept;
    logic           i_last;
    logic           c_last;
    logic           clr_last;

    assign n_lim = (int'(cfg.rows_used) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(cfg.rows_used);
    assign k_lim = (int'(cfg.cols_used) > MAX_RANK) ? KW'(MAX_RANK) : KW'(cfg.cols_used);

    assign accept   = start && (state_reg == S_IDLE);
    assign i_last   = (NW'(i_reg) + NW'(1)) == n_lim;
    assign c_last   = (KW'(c_reg) + KW'(1)) == k_lim;
    assign clr_last = clr_reg == AAW'(MAX_ORDER * MAX_ORDER - 1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        c_next     = c_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_LOAD_X: cmd.load_x = 1'b1;
                        KIND_LOAD_A: cmd.load_a = 1'b1;
                        KIND_READ:   cmd.read_a = 1'b1;
                        KIND_UPDATE:
                        begin
                            cmd.set_live = 1'b1;
                            clr_next     = '0;
                            state_next   = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_flag = 1'b1;
                clr_next     = clr_reg + AAW'(1);
                if (clr_last)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = (n_lim == '0) ? S_IDLE : S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                cmd.a_rd_old = 1'b1;
                c_next       = '0;
                if (k_lim == '0)
                begin
                    cmd.sum_zero = 1'b1;
                    state_next   = S_SCL_LO;
                end
                else
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (c_reg == '0);
                cmd.mac_last  = c_last;
                c_next        = c_reg + RW'(1);
                if (c_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.sum_done)
                begin
                    state_next = S_SCL_LO;
                end
            end
            S_SCL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_SCL_HI;
            end
            S_SCL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_back = 1'b1;
                state_next     = S_ENTRY;
                if (j_reg == i_reg)
                begin
                    if (i_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + OW'(1);
                        j_next = '0;
                    end
                end
                else
                begin
                    j_next = j_reg + OW'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            c_reg     <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            c_reg     <= c_next;
            clr_reg   <= clr_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign i_idx    = i_reg;
    assign j_idx    = j_reg;
    assign c_idx    = c_reg;
    assign clr_addr = clr_reg;

endmodule

// ===== rtl/srk_dpath.sv =====
// ----------------------------------------------------------------------------
// srk_dpath
// Datapath: x, A and clip-flag stores, shared 33x33 multiplier, MAC
// pipeline, alpha scaling, rounding, saturation and the read result.
// ----------------------------------------------------------------------------
module srk_dpath #(
    parameter  int MAX_ORDER = 8,
    parameter  int MAX_RANK  = 8,
    localparam int OW    = $clog2(MAX_ORDER),
    localparam int RW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
    localparam int AAW   = $clog2(MAX_ORDER * MAX_ORDER),
    localparam int XAW   = $clog2(MAX_ORDER * MAX_RANK),
    localparam int SUM_W = 48 + $clog2(MAX_RANK + 1),
    localparam int SCL_W = 32 + SUM_W,
    localparam int RND_W = SCL_W - 16,
    localparam int VW    = RND_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srk_pkg::cfg_t      cfg,
    input  srk_pkg::cmd_t      cmd,
    output srk_pkg::status_t   status,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [31:0] value,
    input  logic [OW-1:0]      i_idx,
    input  logic [OW-1:0]      j_idx,
    input  logic [RW-1:0]      c_idx,
    input  logic [AAW-1:0]     clr_addr,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic               saturated
);
    import srk_pkg::*;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    logic [31:0] x_mem [MAX_ORDER * MAX_RANK];
    logic [31:0] a_mem [MAX_ORDER * MAX_ORDER];
    logic        clip_mem [MAX_ORDER * MAX_ORDER];

    logic [2:0]         hi_idx, lo_idx;
    logic               x_ld_ok, a_in_range;
    logic [XAW-1:0]     x_ld_addr, xi_addr, xj_addr;
    logic [AAW-1:0]     a_io_addr, upd_addr;

    logic               a_we, a_re, clip_we, clip_wdata;
    logic [AAW-1:0]     a_waddr, a_raddr, clip_waddr;
    logic [31:0]        a_wdata;

    logic signed [31:0] xi_reg, xj_reg;
    logic [31:0]        a_rd_reg;
    logic               clip_rd_reg;
    logic               oor_reg;
    logic               rd_valid_reg;
    logic               live_reg;

    logic               v1_reg, f1_reg, l1_reg;
    logic               v2_reg, f2_reg, l2_reg;
    logic               v3_reg, f3_reg, l3_reg;
    logic               done_reg;

    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      mul_p;
    logic signed [65:0]      prod_reg;
    logic signed [63:0]      lo_reg;
    logic [63:0]             mac_biased;
    logic signed [47:0]      rnd_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-33:0] sum_hi;
    logic [SCL_W-1:0]        scaled_reg;
    logic [SCL_W-1:0]        scl_biased;
    logic signed [RND_W-1:0] rounded_reg;
    logic signed [31:0]      a_old;
    logic signed [VW-1:0]    v_sum;
    logic                    ovf;
    logic [31:0]             sat_value;

    // index decode, A is addressed through its lower triangle
    assign hi_idx     = (col > row) ? col : row;
    assign lo_idx     = (col > row) ? row : col;
    assign x_ld_ok    = (int'(row) < MAX_ORDER) && (int'(col) < MAX_RANK);
    assign a_in_range = int'(hi_idx) < MAX_ORDER;
    assign x_ld_addr  = XAW'(int'(row) * MAX_RANK + int'(col));
    assign a_io_addr  = AAW'(int'(hi_idx) * MAX_ORDER + int'(lo_idx));
    assign upd_addr   = AAW'(int'(i_idx) * MAX_ORDER + int'(j_idx));
    assign xi_addr    = XAW'(int'(i_idx) * MAX_RANK + int'(c_idx));
    assign xj_addr    = XAW'(int'(j_idx) * MAX_RANK + int'(c_idx));

    always_ff @(posedge clk)
    begin
        if (cmd.load_x && x_ld_ok)
        begin
            x_mem[x_ld_addr] <= value;
        end
        if (cmd.mac_issue)
        begin
            xi_reg <= x_mem[xi_addr];
            xj_reg <= x_mem[xj_addr];
        end
    end

    assign a_we    = (cmd.load_a && a_in_range) || cmd.write_back;
    assign a_waddr = cmd.write_back ? upd_addr : a_io_addr;
    assign a_wdata = cmd.write_back ? sat_value : value;
    assign a_re    = cmd.read_a || cmd.a_rd_old;
    assign a_raddr = cmd.a_rd_old ? upd_addr : a_io_addr;

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= a_wdata;
        end
        if (a_re)
        begin
            a_rd_reg <= a_mem[a_raddr];
        end
    end

    assign clip_we    = cmd.clr_flag || cmd.write_back;
    assign clip_waddr = cmd.clr_flag ? clr_addr : upd_addr;
    assign clip_wdata = cmd.write_back && ovf;

    always_ff @(posedge clk)
    begin
        if (clip_we)
        begin
            clip_mem[clip_waddr] <= clip_wdata;
        end
        if (cmd.read_a)
        begin
            clip_rd_reg <= clip_mem[a_io_addr];
            oor_reg     <= !a_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            live_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            f1_reg       <= 1'b0;
            l1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            f2_reg       <= 1'b0;
            l2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            f3_reg       <= 1'b0;
            l3_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read_a;
            if (cmd.set_live)
            begin
                live_reg <= 1'b1;
            end
            v1_reg   <= cmd.mac_issue;
            f1_reg   <= cmd.mac_first;
            l1_reg   <= cmd.mac_last;
            v2_reg   <= v1_reg;
            f2_reg   <= f1_reg;
            l2_reg   <= l1_reg;
            v3_reg   <= v2_reg;
            f3_reg   <= f2_reg;
            l3_reg   <= l2_reg;
            done_reg <= v3_reg && l3_reg;
        end
    end

    // shared multiplier: x products while the MAC pipe runs, alpha*sum halves after
    assign sum_hi = sum_reg[SUM_W-1:32];
    assign mul_a  = v1_reg ? 33'(xi_reg) : 33'($signed(cfg.alpha));
    assign mul_b  = v1_reg ? 33'(xj_reg) :
                    (cmd.mul_lo ? $signed({1'b0, sum_reg[31:0]}) : 33'(sum_hi));
    assign mul_p  = mul_a * mul_b;

    assign mac_biased = prod_reg[63:0] + 64'd32768;
    assign scl_biased = scaled_reg + SCL_W'(32768);

    assign a_old = $signed(a_rd_reg);
    assign v_sum = VW'(rounded_reg) + (cfg.accumulate ? VW'(a_old) : VW'(0));
    assign ovf   = v_sum[VW-1:31] != {(VW - 31){v_sum[31]}};
    assign sat_value = !ovf ? v_sum[31:0] : (v_sum[VW-1] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge clk)
    begin
        if (v1_reg || cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_hi)
        begin
            lo_reg <= prod_reg[63:0];
        end
        if (v2_reg)
        begin
            rnd_reg <= mac_biased[63:16];
        end
        if (cmd.sum_zero)
        begin
            sum_reg <= '0;
        end
        else if (v3_reg)
        begin
            sum_reg <= f3_reg ? SUM_W'(rnd_reg) : sum_reg + SUM_W'(rnd_reg);
        end
        if (cmd.combine)
        begin
            scaled_reg <= {prod_reg[SUM_W-1:0], 32'd0} + SCL_W'(lo_reg);
        end
        if (cmd.rnd)
        begin
            rounded_reg <= scl_biased[SCL_W-1:16];
        end
    end

    assign status.sum_done = done_reg;

    assign done       = rd_valid_reg;
    assign read_value = oor_reg ? 32'sd0 : $signed(a_rd_reg);
    assign saturated  = clip_rd_reg && live_reg && !oor_reg;

endmodule

// ===== rtl/srk_checker.sv =====
// ----------------------------------------------------------------------------
// srk_port_checker
// Port-level checks on transaction sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module srk_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] kind,
    input logic       done
);
    import srk_pkg::*;

    logic acc;
    assign acc = start && !busy;

    // a result only ever answers a read taken the cycle before
    a_done_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc && (kind == KIND_READ)))
        else $error("done without a preceding read transaction");

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (kind == KIND_READ)) |=> done)
        else $error("read transaction gave no result");

    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (kind == KIND_UPDATE)) |=> busy)
        else $error("update did not raise busy");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && ((kind == KIND_LOAD_X) || (kind == KIND_LOAD_A))) |=> (!busy && !done))
        else $error("load raised busy or gave a result");

endmodule

bind symmetric_rank_k_update srk_port_checker u_srk_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .kind  (kind),
    .done  (done)
);
